// ----- rtl/core/lsbie_pkg.sv -----
package lsbie_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // operating modes
  localparam logic MODE_HIDE    = 1'b0;
  localparam logic MODE_RECOVER = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_CARRIER = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PIXEL   = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  // header is four carrier pixels long
  localparam logic [2:0] HDR_LEN = 3'd4;

  localparam logic [7:0] KEEP_MASK = 8'hFC;
  localparam logic [1:0] GROUP_LAST = 2'd3;

  localparam int DIM_W   = 12;
  localparam int PIX_W   = 24;
  localparam int COUNT_W = 24;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [PIX_W-1:0] pix_t;

endpackage

// ----- rtl/core/lsb_image_embed_extract.sv -----
// Two-bit-per-channel RGB steganography engine. One carrier pixel is taken per
// beat and the block sustains one beat per clock: each pixel passes through one
// layer of mask/shift logic into the output register, so results appear in the
// cycle after acceptance and in_ready only drops while a finished result is
// stalled at the output. An image begins with a four-pixel header (width, then
// height, 12 bits each, top bit pair first, r/g/b order); each secret pixel then
// spans four carrier pixels. In hide mode (mode = 0) every carrier pixel comes
// out as kind 0 with its two low bits per channel replaced, and pixels after the
// payload pass unchanged. In recover mode (mode = 1) one header result (kind 1)
// is given after the fourth carrier pixel, then one recovered pixel (kind 2) per
// four carriers until width*height pixels are out; other carriers give nothing.
// frame_start on a beat restarts the image. The width*height product is kept in
// a register updated together with the held dimensions. Configuration writes
// take effect at once and belong between images while the block is idle.
module lsb_image_embed_extract import lsbie_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  carrier_r,
  input  logic [7:0]  carrier_g,
  input  logic [7:0]  carrier_b,
  input  logic [7:0]  secret_r,
  input  logic [7:0]  secret_g,
  input  logic [7:0]  secret_b,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_r,
  output logic [7:0]  out_g,
  output logic [7:0]  out_b,
  output logic [1:0]  out_kind,
  output logic [11:0] rec_width,
  output logic [11:0] rec_height
);

  // configuration registers
  logic               mode;
  dim_t               secret_width;
  dim_t               secret_height;

  // image state
  logic [1:0]         group_phase;
  logic [2:0]         header_index;
  logic [COUNT_W-1:0] pixel_count;
  pix_t               bit_accumulator;
  pix_t               secret_hold;
  dim_t               width_hold;
  dim_t               height_hold;
  logic [COUNT_W-1:0] total;

  logic               in_fire;

  // state as seen after an optional frame restart
  logic [1:0]         gp;
  logic [2:0]         hi;
  logic [COUNT_W-1:0] pc;
  pix_t               acc;
  logic               in_header;
  logic               in_payload;
  logic [5:0]         bits;
  pix_t               sec;
  pix_t               hold_sel;
  dim_t               dim;
  logic [5:0]         dim_half;
  logic [5:0]         pay_slice;

  logic [1:0]         group_phase_next;
  logic [2:0]         header_index_next;
  logic [COUNT_W-1:0] pixel_count_next;
  pix_t               bit_accumulator_next;
  pix_t               secret_hold_next;
  dim_t               width_hold_next;
  dim_t               height_hold_next;
  logic [COUNT_W-1:0] total_next;

  logic               emit;
  logic [7:0]         res_r;
  logic [7:0]         res_g;
  logic [7:0]         res_b;
  logic [1:0]         res_kind;

  // output register frees up when empty or being taken
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_HIDE;
      secret_width  <= '0;
      secret_height <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode <= cfg_data[0];
        REG_WIDTH:  secret_width <= cfg_data;
        REG_HEIGHT: secret_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame restart clears counters before the pixel is handled
  assign gp  = frame_start ? '0 : group_phase;
  assign hi  = frame_start ? '0 : header_index;
  assign pc  = frame_start ? '0 : pixel_count;
  assign acc = frame_start ? '0 : bit_accumulator;

  assign in_header  = (hi < HDR_LEN);
  assign in_payload = (pc < total);
  assign bits       = {carrier_r[1:0], carrier_g[1:0], carrier_b[1:0]};
  assign sec        = {secret_r, secret_g, secret_b};

  // hide side: dimension pairs and payload pairs
  assign hold_sel = (gp == 2'd0) ? sec : secret_hold;

  always_comb begin
    case (gp)
      2'd0:    pay_slice = hold_sel[23:18];
      2'd1:    pay_slice = hold_sel[17:12];
      2'd2:    pay_slice = hold_sel[11:6];
      default: pay_slice = hold_sel[5:0];
    endcase
  end

  assign dim      = (hi < 3'd2) ? ((hi == 3'd0) ? secret_width : width_hold)
                                : height_hold;
  assign dim_half = hi[0] ? dim[5:0] : dim[11:6];

  // per-pixel step
  always_comb begin
    group_phase_next     = gp;
    header_index_next    = hi;
    pixel_count_next     = pc;
    bit_accumulator_next = acc;
    secret_hold_next     = secret_hold;
    width_hold_next      = width_hold;
    height_hold_next     = height_hold;
    emit                 = 1'b0;
    res_r                = '0;
    res_g                = '0;
    res_b                = '0;
    res_kind             = KIND_CARRIER;

    if (mode == MODE_HIDE) begin
      emit = 1'b1;
      if (in_header) begin
        if (hi == 3'd0) begin
          width_hold_next  = secret_width;
          height_hold_next = secret_height;
        end
        res_r             = (carrier_r & KEEP_MASK) | {6'd0, dim_half[5:4]};
        res_g             = (carrier_g & KEEP_MASK) | {6'd0, dim_half[3:2]};
        res_b             = (carrier_b & KEEP_MASK) | {6'd0, dim_half[1:0]};
        header_index_next = hi + 3'd1;
      end else if (in_payload) begin
        secret_hold_next = hold_sel;
        res_r            = (carrier_r & KEEP_MASK) | {6'd0, pay_slice[5:4]};
        res_g            = (carrier_g & KEEP_MASK) | {6'd0, pay_slice[3:2]};
        res_b            = (carrier_b & KEEP_MASK) | {6'd0, pay_slice[1:0]};
        group_phase_next = gp + 2'd1;
        if (gp == GROUP_LAST) begin
          pixel_count_next = pc + COUNT_W'(1);
        end
      end else begin
        res_r = carrier_r;
        res_g = carrier_g;
        res_b = carrier_b;
      end
    end else begin
      if (in_header) begin
        if (hi[0] == 1'b0) begin
          bit_accumulator_next = {18'd0, bits};
        end else begin
          bit_accumulator_next = {12'd0, acc[5:0], bits};
        end
        if (hi == 3'd1) begin
          width_hold_next = bit_accumulator_next[11:0];
        end else if (hi == 3'd3) begin
          height_hold_next = bit_accumulator_next[11:0];
          emit             = 1'b1;
          res_kind         = KIND_HEADER;
        end
        header_index_next = hi + 3'd1;
      end else if (in_payload) begin
        if (gp == 2'd0) begin
          bit_accumulator_next = {18'd0, bits};
        end else begin
          bit_accumulator_next = {acc[17:0], bits};
        end
        if (gp == GROUP_LAST) begin
          res_r            = bit_accumulator_next[23:16];
          res_g            = bit_accumulator_next[15:8];
          res_b            = bit_accumulator_next[7:0];
          emit             = 1'b1;
          res_kind         = KIND_PIXEL;
          pixel_count_next = pc + COUNT_W'(1);
        end
        group_phase_next = gp + 2'd1;
      end
    end
  end

  // pixel total tracks the held dimensions
  assign total_next = {12'd0, width_hold_next} * {12'd0, height_hold_next};

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase     <= '0;
      header_index    <= '0;
      pixel_count     <= '0;
      bit_accumulator <= '0;
      secret_hold     <= '0;
      width_hold      <= '0;
      height_hold     <= '0;
      total           <= '0;
    end else if (in_fire) begin
      group_phase     <= group_phase_next;
      header_index    <= header_index_next;
      pixel_count     <= pixel_count_next;
      bit_accumulator <= bit_accumulator_next;
      secret_hold     <= secret_hold_next;
      width_hold      <= width_hold_next;
      height_hold     <= height_hold_next;
      total           <= total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_r      <= res_r;
      out_g      <= res_g;
      out_b      <= res_b;
      out_kind   <= res_kind;
      rec_width  <= width_hold_next;
      rec_height <= height_hold_next;
    end
  end

`ifndef SYNTHESIS
  // header counter saturates at the header length
  assert property (@(posedge clk) disable iff (rst) header_index <= HDR_LEN)
    else $error("header_index ran past header length");

  // payload groups only advance once the header is complete
  assert property (@(posedge clk) disable iff (rst)
    group_phase != 2'd0 |-> header_index == HDR_LEN)
    else $error("group_phase moved during header");

  // a new beat is never taken over a stalled result
  assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (!out_valid || out_ready))
    else $error("beat accepted while result stalled");

  // the unused kind code never appears
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_kind != KIND_UNUSED)
    else $error("invalid result kind");
`endif

endmodule
